@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the set membership engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a disable condition.
`define ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication under a disable condition.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/sibs_pkg.sv @@
// ----------------------------------------------------------------------------
// sibs_pkg
// Types and constants shared by the set membership engine.
// ----------------------------------------------------------------------------
package sibs_pkg;

  localparam int unsigned ELEM_W            = 32;
  localparam int unsigned CMD_W             = 2;
  localparam int unsigned SET_DEPTH_DEFAULT = 256;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Command codes; the remaining code is ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_PROBE = 2'd2
  } cmd_t;

endpackage

@@ hdl/sibs_in_if.sv @@
// ----------------------------------------------------------------------------
// sibs_in_if
// Command channel: valid/ready with command and element payload.
// ----------------------------------------------------------------------------
interface sibs_in_if;
  import sibs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  elem_t               element_value;

  modport source (output valid, output cmd, output element_value, input ready);
  modport sink   (input valid, input cmd, input element_value, output ready);
endinterface

@@ hdl/sibs_out_if.sv @@
// ----------------------------------------------------------------------------
// sibs_out_if
// Result channel: valid/ready with the matched element.
// ----------------------------------------------------------------------------
interface sibs_out_if;
  import sibs_pkg::*;

  logic  valid;
  logic  ready;
  elem_t match_value;

  modport source (output valid, output match_value, input ready);
  modport sink   (input valid, input match_value, output ready);
endinterface

@@ hdl/set_intersection_binary_search.sv @@
// ----------------------------------------------------------------------------
// set_intersection_binary_search
// Set membership engine. A clear transfer empties the reference set. An add
// transfer inserts its element into a store kept in ascending signed
// order: the sequencer walks down from the top entry, moving each larger
// entry up by one slot through the single write port, and an add to an
// empty store writes the bottom entry directly; adds to a full store are
// dropped. A probe transfer binary-searches the store with one memory read
// per cycle; a match then waits in the emit state until the output register
// takes it. A probe that hits yields one result transfer carrying the
// probed value; a miss, or a probe against an empty set, yields none. The
// output register lets the next command start while a result waits. The
// store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module set_intersection_binary_search #(
  parameter int unsigned SET_DEPTH = sibs_pkg::SET_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  sibs_in_if.sink    in_ch,
  sibs_out_if.source out_ch
);
  import sibs_pkg::*;

  localparam int unsigned AW = $clog2(SET_DEPTH);

  // store port between sequencer and memory
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  elem_t         wr_data;
  logic [AW-1:0] rd_addr;
  elem_t         rd_data;

  // sequencer to output register
  logic  res_valid;
  logic  res_ready;
  elem_t res_value;

  // output register
  logic  out_valid_r;
  elem_t out_value_r;

  sibs_seq #(
    .SET_DEPTH (SET_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_value  (in_ch.element_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  sibs_store #(
    .DEPTH (SET_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Take a new result when the register is empty or drains this cycle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      // drop the flag once the waiting result has been transferred
      out_valid_r <= 1'b0;
    end
  end

  // Hold the value while the sink stalls.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value_r <= res_value;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_value = out_value_r;

endmodule

@@ hdl/sibs_store.sv @@
// ----------------------------------------------------------------------------
// sibs_store
// Sorted element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sibs_store #(
  parameter int unsigned DEPTH = sibs_pkg::SET_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  sibs_pkg::elem_t              wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output sibs_pkg::elem_t              rd_data
);
  import sibs_pkg::*;

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/sibs_seq.sv @@
// ----------------------------------------------------------------------------
// sibs_seq
// Command sequencer: insertion walk for adds, binary search for probes.
// ----------------------------------------------------------------------------
module sibs_seq #(
  parameter int unsigned SET_DEPTH = sibs_pkg::SET_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command side
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sibs_pkg::CMD_W-1:0]     in_cmd,
  input  sibs_pkg::elem_t                in_value,
  // result side
  output logic                           res_valid,
  input  logic                           res_ready,
  output sibs_pkg::elem_t                res_value,
  // store port
  output logic                           wr_en,
  output logic [$clog2(SET_DEPTH)-1:0]   wr_addr,
  output sibs_pkg::elem_t                wr_data,
  output logic [$clog2(SET_DEPTH)-1:0]   rd_addr,
  input  sibs_pkg::elem_t                rd_data
);
  import sibs_pkg::*;

  localparam int unsigned AW = $clog2(SET_DEPTH);
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_PLACE = 5'b00100,
    S_SRCH  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [AW-1:0]  mid_r, mid_nxt;
  elem_t          val_r, val_nxt;
  logic [CW:0]    span_sum;
  logic [CW-1:0]  lo_try, hi_try;

  assign res_value = val_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    val_nxt   = val_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data;
    rd_addr   = mid_r;
    in_ready  = (state_r == S_IDLE);
    res_valid = 1'b0;
    lo_try    = lo_r;
    hi_try    = hi_r;
    span_sum  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_ADD: begin
              if (count_r != CW'(SET_DEPTH)) begin
                if (count_r == '0) begin
                  // empty store: place directly at the bottom
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = in_value;
                  count_nxt = CW'(1);
                end else begin
                  idx_nxt   = AW'(count_r);
                  rd_addr   = AW'(count_r - CW'(1));
                  state_nxt = S_INS;
                end
              end
            end
            CMD_PROBE: begin
              if (count_r != '0) begin
                lo_nxt    = '0;
                hi_nxt    = count_r;
                rd_addr   = AW'(count_r >> 1);
                mid_nxt   = AW'(count_r >> 1);
                state_nxt = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // rd_data holds entry idx_r-1
        if (rd_data > val_r) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr = idx_r - AW'(2);
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          wr_data   = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_IDLE;
      end

      S_SRCH: begin
        // rd_data holds entry mid_r
        if (rd_data == val_r) begin
          state_nxt = S_EMIT;
        end else begin
          if (rd_data < val_r) begin
            lo_try = CW'(mid_r) + CW'(1);
          end else begin
            hi_try = CW'(mid_r);
          end
          lo_nxt = lo_try;
          hi_nxt = hi_try;
          if (lo_try < hi_try) begin
            span_sum = {1'b0, lo_try} + {1'b0, hi_try};
            rd_addr  = AW'(span_sum >> 1);
            mid_nxt  = AW'(span_sum >> 1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    val_r <= val_nxt;
  end

endmodule

@@ hdl/sibs_checker.sv @@
// ----------------------------------------------------------------------------
// sibs_checker
// Port-level checks for the set membership engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sibs_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sibs_pkg::elem_t       out_value
);
  import sibs_pkg::*;

  // A stalled result keeps its flag and its value.
  `ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, !rst_n, out_valid && !out_ready, $stable(out_value))

  // Reset empties the output register.
  `ASSERT_NEXT(a_rst_empty, clk, 1'b0, !rst_n, !out_valid)

  // A result only appears right after the engine was busy.
  `ASSERT_IMPLY(a_res_busy, clk, !rst_n, $rose(out_valid) && $past(rst_n), !$past(in_ready))

endmodule

bind set_intersection_binary_search sibs_checker u_sibs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.match_value)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set membership engine. A directed table runs
// the corner cases first (empty set, extreme values, duplicates, the unused
// command, clear), then random clear/fill/probe sequences follow. Every
// accepted command updates a local sorted copy of the reference set, and each
// probe that hits queues the value it must return. Result transfers are
// compared in order against that queue. Sender gaps and receiver stalls
// rotate through several pressure phases.
// ----------------------------------------------------------------------------
module testbench;
  import sibs_pkg::*;

  localparam int unsigned SET_DEPTH    = SET_DEPTH_DEFAULT;
  localparam int          ITEM_TARGET  = 1800;
  localparam int          PHASE_ITEMS  = 150;
  // An add into a store one short of full moves every entry; leave room for that.
  localparam int          DRAIN_CYCLES = 2 * SET_DEPTH + 16;
  localparam int          RUN_LIMIT_NS = 20_000_000;

  // Code that the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam elem_t ELEM_MIN = 32'sh8000_0000;
  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;

  // One directed command; when typed is set, hit is the known outcome.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    elem_t            value;
    logic             typed;
    logic             hit;
  } plan_row_t;

  logic clk;
  logic rst_n;

  sibs_in_if  in_ch ();
  sibs_out_if out_ch ();

  set_intersection_binary_search #(
    .SET_DEPTH (SET_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the reference set, ascending signed order.
  elem_t       member_store [SET_DEPTH];
  int unsigned member_count;

  // Values that the block still owes us, oldest first.
  elem_t       expected_matches [$];

  int          fail_count;
  int          sent_count;

  // Directed table: empty set first, then extremes, duplicates, the unused
  // code, clear and a small set.
  plan_row_t plan [23] = '{
    '{CMD_PROBE,  32'sd0,  1'b1, 1'b0},   // empty after reset
    '{CMD_PROBE,  ELEM_MIN, 1'b1, 1'b0},
    '{CMD_UNUSED, 32'sd5,  1'b1, 1'b0},   // ignored, no result
    '{CMD_ADD,    ELEM_MAX, 1'b0, 1'b0},
    '{CMD_ADD,    ELEM_MIN, 1'b0, 1'b0},
    '{CMD_ADD,    32'sd0,  1'b0, 1'b0},
    '{CMD_ADD,    -32'sd1, 1'b0, 1'b0},
    '{CMD_ADD,    32'sd0,  1'b0, 1'b0},   // duplicate stored twice
    '{CMD_PROBE,  ELEM_MAX, 1'b1, 1'b1},
    '{CMD_PROBE,  ELEM_MIN, 1'b1, 1'b1},
    '{CMD_PROBE,  32'sd0,  1'b1, 1'b1},   // one result despite two copies
    '{CMD_PROBE,  32'sd0,  1'b1, 1'b1},   // repeated probe hits again
    '{CMD_PROBE,  32'sd1,  1'b0, 1'b0},
    '{CMD_PROBE,  -32'sd1, 1'b0, 1'b0},
    '{CMD_PROBE,  32'sh7FFF_FFFE, 1'b0, 1'b0},
    '{CMD_UNUSED, 32'sd0,  1'b1, 1'b0},   // must not disturb the set
    '{CMD_PROBE,  -32'sd1, 1'b0, 1'b0},
    '{CMD_CLEAR,  32'sd0,  1'b1, 1'b0},
    '{CMD_PROBE,  32'sd0,  1'b1, 1'b0},   // empty after clear
    '{CMD_PROBE,  ELEM_MAX, 1'b1, 1'b0},
    '{CMD_ADD,    32'sd42, 1'b0, 1'b0},
    '{CMD_PROBE,  32'sd42, 1'b0, 1'b0},
    '{CMD_PROBE,  32'sd41, 1'b0, 1'b0}
  };

  // Pressure phases rotate with the number of accepted commands:
  // none, sender gaps, receiver stalls, both.
  function automatic int sender_idle_pct();
    case ((sent_count / PHASE_ITEMS) % 4)
      1:       return 70;
      3:       return 22;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((sent_count / PHASE_ITEMS) % 4)
      2:       return 70;
      3:       return 22;
      default: return 0;
    endcase
  endfunction

  // Apply one command to the local set; return 1 when a probe hits.
  function automatic bit apply_command(logic [CMD_W-1:0] cmd, elem_t value);
    int unsigned pos;
    bit          hit;
    hit = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        member_count = 0;
      end
      CMD_ADD: begin
        // Drop the add when the store is full; else insert in order.
        if (member_count < SET_DEPTH) begin
          pos = member_count;
          while (pos > 0 && member_store[pos-1] > value) begin
            member_store[pos] = member_store[pos-1];
            pos--;
          end
          member_store[pos] = value;
          member_count++;
        end
      end
      CMD_PROBE: begin
        for (int unsigned i = 0; i < member_count; i++) begin
          if (member_store[i] == value) hit = 1'b1;
        end
      end
      default: begin
        // Unused code: no state change, no result.
      end
    endcase
    return hit;
  endfunction

  function automatic elem_t extreme_elem();
    case ($urandom_range(3))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Adds cluster around a base so that probes find neighbors and duplicates.
  function automatic elem_t pick_add_value(elem_t base);
    int r;
    r = $urandom_range(99);
    if (r < 60) return base + elem_t'($urandom_range(40)) - 32'sd20;
    if (r < 85) return elem_t'($urandom);
    if (r < 95 || member_count == 0) return extreme_elem();
    return member_store[$urandom_range(member_count - 1)];
  endfunction

  function automatic elem_t pick_probe_value(elem_t base);
    int    r;
    elem_t picked;
    r = $urandom_range(99);
    if (member_count != 0 && r < 65) begin
      picked = member_store[$urandom_range(member_count - 1)];
      if (r < 50) return picked;
      return $urandom_range(1) ? picked + 32'sd1 : picked - 32'sd1;
    end
    if (r < 80) return base + elem_t'($urandom_range(40)) - 32'sd20;
    if (r < 90) return elem_t'($urandom);
    return extreme_elem();
  endfunction

  // Drive one command and hold it until the transfer; entered just after a
  // rising edge, returns on the edge of the transfer.
  task automatic send_command(logic [CMD_W-1:0] cmd, elem_t value,
                              bit typed, bit typed_hit);
    bit hit;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.element_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Keep the local set in step; a typed outcome overrides the prediction.
    hit = apply_command(cmd, value);
    if (typed) hit = typed_hit;
    if (hit) expected_matches = {expected_matches, value};
    sent_count++;
  endtask

  // One random sequence: usually clear, fill, then probe with some noise.
  // Every thirtieth sequence fills the store past its capacity.
  task automatic run_sequence(int seq_idx);
    elem_t base;
    int    fill_len;
    int    probe_len;
    int    r;
    base = ($urandom_range(3) == 0) ? extreme_elem() : elem_t'($urandom);
    if ($urandom_range(9) != 0) send_command(CMD_CLEAR, elem_t'($urandom), 1'b0, 1'b0);
    if (seq_idx % 30 == 7) fill_len = SET_DEPTH + 3;
    else                   fill_len = $urandom_range(14);
    for (int i = 0; i < fill_len; i++) begin
      if ($urandom_range(19) == 0)
        send_command(CMD_UNUSED, elem_t'($urandom), 1'b0, 1'b0);
      send_command(CMD_ADD, pick_add_value(base), 1'b0, 1'b0);
    end
    probe_len = $urandom_range(24, 4);
    for (int i = 0; i < probe_len; i++) begin
      r = $urandom_range(99);
      if (r < 5)       send_command(CMD_UNUSED, elem_t'($urandom), 1'b0, 1'b0);
      else if (r < 12) send_command(CMD_ADD, pick_add_value(base), 1'b0, 1'b0);
      else             send_command(CMD_PROBE, pick_probe_value(base), 1'b0, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: drop ready at random according to the current phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Compare each result transfer with the oldest pending match.
  always @(posedge clk) begin : result_check
    elem_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_matches.size() == 0) begin
        $error("match_value: expected no result, actual %0d", out_ch.match_value);
        fail_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_ch.match_value !== want) begin
          $error("match_value: expected %0d, actual %0d", want, out_ch.match_value);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random sequences, drain, verdict.
  initial begin
    int seq_idx;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_CLEAR;
    in_ch.element_value = '0;
    member_count        = 0;
    fail_count          = 0;
    sent_count          = 0;
    seq_idx             = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(plan); i++) begin
      send_command(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].hit);
    end

    while (sent_count < ITEM_TARGET) begin
      run_sequence(seq_idx);
      seq_idx++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for the last matches, then give a slow add time to show a stray
    // result.
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ set_intersection_binary_search.f @@
+incdir+hdl
hdl/sibs_pkg.sv
hdl/sibs_in_if.sv
hdl/sibs_out_if.sv
hdl/sibs_store.sv
hdl/sibs_seq.sv
hdl/set_intersection_binary_search.sv
hdl/sibs_checker.sv
dv/testbench.sv
